[hw/rtl/sha1md_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest block: the command
// and status groups between controller and datapath, initial hash values and
// round constants.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned NumRounds = 80;

  localparam logic [31:0] Iv0 = 32'h6745_2301;
  localparam logic [31:0] Iv1 = 32'hEFCD_AB89;
  localparam logic [31:0] Iv2 = 32'h98BA_DCFE;
  localparam logic [31:0] Iv3 = 32'h1032_5476;
  localparam logic [31:0] Iv4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [2:0] WordLast  = 3'd4;

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_MARK  = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      push;
    byte_src_t src;
    logic      count_inc;
    logic      len_load;
    logic      round_load;
    logic      round_step;
    logic      fold;
    logic      word_next;
    logic      reinit;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_len_pos;
    logic round_last;
    logic word_last;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/sha1md_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Controller: sequences byte absorption, block compression, message padding
// and the five-word digest output.
// ----------------------------------------------------------------------------
module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic    byte_valid,
  input  wire logic    end_of_message,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_MARK  = 7'b000_0010,
    S_ZERO  = 7'b000_0100,
    S_LEN   = 7'b000_1000,
    S_ROUND = 7'b001_0000,
    S_FOLD  = 7'b010_0000,
    S_EMIT  = 7'b100_0000
  } state_t;

  state_t state, state_next;
  state_t resume, resume_next;

  // handshake outputs straight from the state register
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);

  // next state and commands
  always_comb begin
    state_next  = state;
    resume_next = resume;
    cmd         = '0;
    cmd.src     = SRC_INPUT;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_valid) begin
            cmd.push      = 1'b1;
            cmd.src       = SRC_INPUT;
            cmd.count_inc = 1'b1;
          end
          if (byte_valid && status.fill_last) begin
            cmd.round_load = 1'b1;
            state_next     = S_ROUND;
            resume_next    = end_of_message ? S_MARK : S_IDLE;
          end else if (end_of_message) begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.len_load = 1'b1;
        cmd.push     = 1'b1;
        cmd.src      = SRC_MARK;
        if (status.fill_last) begin
          cmd.round_load = 1'b1;
          state_next     = S_ROUND;
          resume_next    = S_ZERO;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (status.fill_len_pos) begin
          state_next = S_LEN;
        end else begin
          cmd.push = 1'b1;
          cmd.src  = SRC_ZERO;
          if (status.fill_last) begin
            cmd.round_load = 1'b1;
            state_next     = S_ROUND;
            resume_next    = S_ZERO;
          end
        end
      end
      S_LEN: begin
        // the last length byte always completes the block
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
        if (status.fill_last) begin
          cmd.round_load = 1'b1;
          state_next     = S_ROUND;
          resume_next    = S_EMIT;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = resume;
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.word_next = 1'b1;
          if (status.word_last) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= S_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sha1md_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: block buffer doubling as the message schedule window, one SHA-1
// round per cycle, chaining words, byte and fill counters, length shifter.
// ----------------------------------------------------------------------------
module sha1md_dp
  import sha1md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] data_byte,
  output status_t         status,
  output logic [31:0]     digest_word,
  output logic [2:0]      word_index,
  output logic            last_word
);

  logic [31:0] win [BlkWords];
  logic [31:0] chain [NumWords];
  logic [31:0] va, vb, vc, vd, ve;
  logic [60:0] byte_count;
  logic [63:0] len_sr;
  logic [5:0]  fill;
  logic [6:0]  round_cnt;
  logic [2:0]  word_idx;

  logic [7:0]  push_byte;
  logic [31:0] fn, kc, temp, sched_new;

  function automatic logic [31:0] sched_xor_rot(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  // byte selection for the buffer
  always_comb begin
    case (cmd.src)
      SRC_INPUT: push_byte = data_byte;
      SRC_MARK:  push_byte = PadMark;
      SRC_ZERO:  push_byte = 8'h00;
      SRC_LEN:   push_byte = len_sr[63:56];
      default:   push_byte = 8'h00;
    endcase
  end

  // round function and constant by round range
  always_comb begin
    if (round_cnt < 7'd20) begin
      fn = (vb & vc) | (~vb & vd);
      kc = K0;
    end else if (round_cnt < 7'd40) begin
      fn = vb ^ vc ^ vd;
      kc = K1;
    end else if (round_cnt < 7'd60) begin
      fn = (vb & vc) | (vb & vd) | (vc & vd);
      kc = K2;
    end else begin
      fn = vb ^ vc ^ vd;
      kc = K3;
    end
  end

  assign temp      = {va[26:0], va[31:27]} + fn + ve + kc + win[0];
  assign sched_new = {sched_xor_rot(win[13] ^ win[8] ^ win[2] ^ win[0])};

  // block buffer: bytes shift in at the bottom, schedule words shift by one
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < BlkWords - 1; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[BlkWords-1] <= {win[BlkWords-1][23:0], push_byte};
    end else if (cmd.round_step) begin
      for (int i = 0; i < BlkWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlkWords-1] <= sched_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.round_load) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round_step) begin
      va <= temp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  // length shifter
  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      len_sr <= {byte_count, 3'b000};
    end else if (cmd.push && (cmd.src == SRC_LEN)) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      chain[0] <= Iv0;
      chain[1] <= Iv1;
      chain[2] <= Iv2;
      chain[3] <= Iv3;
      chain[4] <= Iv4;
    end else if (cmd.fold) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
      chain[4] <= chain[4] + ve;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      byte_count <= '0;
      fill       <= '0;
      word_idx   <= '0;
    end else begin
      if (cmd.count_inc) begin
        byte_count <= byte_count + 61'd1;
      end
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.word_next) begin
        word_idx <= word_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.round_load) begin
      round_cnt <= '0;
    end else if (cmd.round_step) begin
      round_cnt <= round_cnt + 7'd1;
    end
  end

  // status and digest output
  assign status.fill_last    = (fill == FillLast);
  assign status.fill_len_pos = (fill == LenOffset);
  assign status.round_last   = (round_cnt == RoundLast);
  assign status.word_last    = (word_idx == WordLast);

  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == WordLast);

endmodule
`default_nettype wire

[hw/rtl/sha1_message_digest.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream; each end of message yields the five digest words
// and restarts the hash for the next message.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   data_byte, byte_valid, end_of_message
//  out      out_valid / out_stall digest_word, word_index, last_word
//
//  a request without a completed block leaves the block idle; a request whose byte
//  fills the block starts its compression: the rounds in the single round unit,
//  then a fold into the chaining words
//  an end of message adds the padding bytes, a step at the length offset, the
//  length bytes and each block's compression, then offers the digest words
//  in_stall is high while a block compresses, the message is padded or the
//  digest is on offer; out_stall holds the current digest word
//  rst is synchronous and loads the initial hash values
// ----------------------------------------------------------------------------
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  cmd_t    cmd;
  status_t status;

  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .cmd            (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // no request taken while a digest is on offer
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken during digest output");

  // digest ends after the final word is taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
    else $error("block not idle after final digest word");

  // word index advances by one per taken word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_word) |=>
      (out_valid && (word_index == $past(word_index) + 3'd1)))
    else $error("digest word index out of sequence");

  // the final word carries the highest index
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == WordLast)))
    else $error("last word flag and index disagree");

endmodule
`default_nettype wire
